// ----- rtl/sevseg_pkg.sv -----
package sevseg_pkg;

  localparam int DIGIT_COUNT = 4;
  localparam int VALUE_W     = 14;
  localparam int SEG_W       = 7;
  localparam int EN_W        = 4;
  localparam int DIGIT_W     = 4;

  localparam int BCD_W = DIGIT_W * DIGIT_COUNT;
  localparam int IDX_W = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;
  localparam int CNT_W = $clog2(VALUE_W);

  // 10 ** DIGIT_COUNT, worked out at elaboration
  function automatic longint pow10(input int n);
    longint p;
    p = 1;
    for (int i = 0; i < n; i++) p = p * 10;
    return p;
  endfunction

  localparam longint VALUE_LIMIT = pow10(DIGIT_COUNT);

  typedef enum logic {
    ACT_LOAD = 1'b0,
    ACT_TICK = 1'b1
  } action_t;

  // gfedcba, bit 0 = segment a, no decimal point bit
  function automatic logic [SEG_W-1:0] seg_pattern(input logic [DIGIT_W-1:0] d);
    logic [SEG_W-1:0] s;
    case (d)
      4'd0:    s = 7'h3F;
      4'd1:    s = 7'h06;
      4'd2:    s = 7'h5B;
      4'd3:    s = 7'h4F;
      4'd4:    s = 7'h66;
      4'd5:    s = 7'h6D;
      4'd6:    s = 7'h7D;
      4'd7:    s = 7'h07;
      4'd8:    s = 7'h7F;
      4'd9:    s = 7'h67;
      default: s = '0;
    endcase
    return s;
  endfunction

endpackage

// ----- rtl/sevseg_item_if.sv -----
interface sevseg_item_if;
  logic                          valid;
  logic                          ready;
  sevseg_pkg::action_t           action;
  logic [sevseg_pkg::VALUE_W-1:0] value;

  modport source (output valid, output action, output value, input ready);
  modport sink   (input valid, input action, input value, output ready);
endinterface

// ----- rtl/sevseg_result_if.sv -----
interface sevseg_result_if;
  logic                          valid;
  logic                          ready;
  logic [sevseg_pkg::SEG_W-1:0]  segments;
  logic [sevseg_pkg::EN_W-1:0]   digit_enable;

  modport source (output valid, output segments, output digit_enable, input ready);
  modport sink   (input valid, input segments, input digit_enable, output ready);
endinterface

// ----- rtl/four_digit_seven_segment_scanner.sv -----
// four-digit multiplexed seven-segment display scanner
//
// item channel: one beat is either a load (action = load, value = number)
// or a refresh tick (action = tick). result channel: one beat per tick,
// carrying the segment pattern (gfedcba) and a one-hot digit enable.
// loads give no result beat; a load of a number at or above 10**digits
// is dropped and the shown digits stay as they were.
//
// a load is converted to decimal by a shift-add-3 sequencer: one shared
// add-3 / shift step per cycle over the 14 value bits, so a load keeps
// item.ready low after its beat until the last step has committed the
// digits, and the new digits show from the next tick on.
// a tick is handled in its accept cycle; its result beat sits in the
// output register from the next cycle, so ticks can run one per cycle
// while the receiver keeps up.
// when the receiver stalls with a result held, item.ready stays low
// until that beat is taken.
// reset (rst, synchronous) clears all digits to zero, points the scan
// at the most significant digit (enable 1) and empties the output.
module four_digit_seven_segment_scanner (
  input  logic             clk,
  input  logic             rst,
  sevseg_item_if.sink      item,
  sevseg_result_if.source  result
);
  import sevseg_pkg::*;

  typedef enum logic {
    ST_IDLE,
    ST_CONV
  } state_t;

  state_t state;

  // digit store, least significant digit at entry 0
  logic [DIGIT_W-1:0] digit_store [DIGIT_COUNT];
  logic [IDX_W-1:0]   scan_idx;

  // conversion datapath
  logic [VALUE_W-1:0] shreg;
  logic [BCD_W-1:0]   bcd;
  logic [CNT_W-1:0]   cnt;
  logic [BCD_W-1:0]   bcd_adj;
  logic [BCD_W-1:0]   bcd_next;
  logic [VALUE_W-1:0] shreg_next;

  // output register
  logic               out_valid;
  logic [SEG_W-1:0]   out_seg;
  logic [EN_W-1:0]    out_en;

  logic               in_fire;
  logic               out_free;
  logic               load_ok;
  logic [IDX_W-1:0]   rd_addr;
  logic [DIGIT_W-1:0] rd_digit;
  logic [EN_W-1:0]    en_next;
  logic [IDX_W-1:0]   idx_next;

  assign out_free = !out_valid || result.ready;
  assign item.ready = (state == ST_IDLE) && out_free;
  assign in_fire = item.valid && item.ready;

  assign load_ok = (longint'(item.value) < VALUE_LIMIT);

  // scan starts at the most significant digit
  assign rd_addr  = IDX_W'(DIGIT_COUNT - 1) - scan_idx;
  assign rd_digit = digit_store[rd_addr];

  // enable bits beyond the field stay off
  assign en_next = (32'(scan_idx) < EN_W) ? (EN_W'(1) << scan_idx) : '0;
  assign idx_next = (scan_idx == IDX_W'(DIGIT_COUNT - 1)) ? '0 : scan_idx + 1'b1;

  // shared step: add 3 to every bcd digit above 4, then shift in one bit
  always_comb begin
    for (int i = 0; i < DIGIT_COUNT; i++) begin
      if (bcd[i*DIGIT_W +: DIGIT_W] > 4'd4) begin
        bcd_adj[i*DIGIT_W +: DIGIT_W] = bcd[i*DIGIT_W +: DIGIT_W] + 4'd3;
      end else begin
        bcd_adj[i*DIGIT_W +: DIGIT_W] = bcd[i*DIGIT_W +: DIGIT_W];
      end
    end
    bcd_next   = {bcd_adj[BCD_W-2:0], shreg[VALUE_W-1]};
    shreg_next = {shreg[VALUE_W-2:0], 1'b0};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      scan_idx  <= '0;
      out_valid <= 1'b0;
      for (int i = 0; i < DIGIT_COUNT; i++) digit_store[i] <= '0;
    end else begin
      // a new tick refills the output register, else a taken beat empties it
      if (in_fire && item.action == ACT_TICK) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (in_fire) begin
            if (item.action == ACT_TICK) begin
              out_seg   <= seg_pattern(rd_digit);
              out_en    <= en_next;
              scan_idx  <= idx_next;
            end else if (load_ok) begin
              shreg <= item.value;
              bcd   <= '0;
              cnt   <= CNT_W'(VALUE_W - 1);
              state <= ST_CONV;
            end
          end
        end
        ST_CONV: begin
          bcd   <= bcd_next;
          shreg <= shreg_next;
          cnt   <= cnt - 1'b1;
          if (cnt == '0) begin
            // last step: commit all digits at once
            for (int i = 0; i < DIGIT_COUNT; i++) begin
              digit_store[i] <= bcd_next[i*DIGIT_W +: DIGIT_W];
            end
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign result.valid        = out_valid;
  assign result.segments     = out_seg;
  assign result.digit_enable = out_en;

  // a new result beat only follows an accepted tick
  a_result_from_tick: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_fire && item.action == ACT_TICK))
    else $error("result beat without a tick");

  // conversion ends after its last step
  a_conv_ends: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CONV && cnt == '0) |=> (state == ST_IDLE))
    else $error("conversion did not finish");

  // no input taken while converting
  a_no_accept_conv: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CONV) |-> !item.ready)
    else $error("input accepted during conversion");

  // the stored digit under the scan is always decimal
  a_digit_decimal: assert property (@(posedge clk) disable iff (rst)
    rd_digit < 4'd10)
    else $error("digit store holds a non-decimal code");

  // at most one digit enabled per beat
  a_enable_onehot: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $onehot0(out_en))
    else $error("digit enable not one-hot");

endmodule

// ----- tb/tb_four_digit_seven_segment_scanner.sv -----
module tb_four_digit_seven_segment_scanner;
  import sevseg_pkg::*;

  // generous ceiling: ~560 items, each with sender gaps, a load conversion
  // or a stalled result beat, stays far below this
  localparam int CYCLE_LIMIT     = 200000;
  // loads give no beat, so the tail waits out a full conversion and more
  localparam int DRAIN_CYCLES    = 40;
  localparam int ITEMS_PER_PHASE = 125;
  localparam int REPORT_MAX      = 10;

  // own glyph table, gfedcba with segment a in bit 0
  localparam logic [SEG_W-1:0] DIGIT_GLYPHS [10] = '{
    7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h67
  };

  typedef struct {
    logic [SEG_W-1:0] segments;
    logic [EN_W-1:0]  enable;
  } display_beat_t;

  // one row of the directed table; typed rows carry their own expected beat
  typedef struct {
    action_t              act;
    logic [VALUE_W-1:0]   value;
    bit                   typed;
    logic [SEG_W-1:0]     segments;
    logic [EN_W-1:0]      enable;
  } stim_row_t;

  // directed stimulus: zeros after reset, both extremes, the too-large drops,
  // and two loads that between them show the digits 1 to 8
  stim_row_t directed_rows [25] = '{
    '{ACT_TICK, 14'd0,     1'b1, 7'h3F, 4'b0001},
    '{ACT_TICK, 14'd16383, 1'b1, 7'h3F, 4'b0010},
    '{ACT_TICK, 14'd0,     1'b1, 7'h3F, 4'b0100},
    '{ACT_TICK, 14'd0,     1'b1, 7'h3F, 4'b1000},
    '{ACT_LOAD, 14'd9999,  1'b0, 7'h00, 4'b0000},
    '{ACT_TICK, 14'd0,     1'b1, 7'h67, 4'b0001},
    '{ACT_TICK, 14'd0,     1'b1, 7'h67, 4'b0010},
    '{ACT_TICK, 14'd0,     1'b1, 7'h67, 4'b0100},
    '{ACT_TICK, 14'd0,     1'b1, 7'h67, 4'b1000},
    '{ACT_LOAD, 14'd16383, 1'b0, 7'h00, 4'b0000},
    '{ACT_TICK, 14'd0,     1'b1, 7'h67, 4'b0001},
    '{ACT_LOAD, 14'd10000, 1'b0, 7'h00, 4'b0000},
    '{ACT_TICK, 14'd0,     1'b1, 7'h67, 4'b0010},
    '{ACT_LOAD, 14'd1234,  1'b0, 7'h00, 4'b0000},
    '{ACT_TICK, 14'd0,     1'b0, 7'h00, 4'b0000},
    '{ACT_TICK, 14'd0,     1'b0, 7'h00, 4'b0000},
    '{ACT_TICK, 14'd0,     1'b0, 7'h00, 4'b0000},
    '{ACT_LOAD, 14'd5678,  1'b0, 7'h00, 4'b0000},
    '{ACT_TICK, 14'd0,     1'b0, 7'h00, 4'b0000},
    '{ACT_TICK, 14'd0,     1'b0, 7'h00, 4'b0000},
    '{ACT_TICK, 14'd0,     1'b0, 7'h00, 4'b0000},
    '{ACT_TICK, 14'd0,     1'b0, 7'h00, 4'b0000},
    '{ACT_LOAD, 14'd0,     1'b0, 7'h00, 4'b0000},
    '{ACT_TICK, 14'd0,     1'b0, 7'h00, 4'b0000},
    '{ACT_TICK, 14'd0,     1'b0, 7'h00, 4'b0000}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;

  sevseg_item_if   item_if ();
  sevseg_result_if result_if ();

  four_digit_seven_segment_scanner i_dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_if),
    .result (result_if)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // shadow of the display: decimal digits (store 0 = ones) and scan position
  logic [DIGIT_W-1:0] shown_digits [DIGIT_COUNT];
  int unsigned        scan_pos;

  display_beat_t pending_beats [$];
  display_beat_t seen_want;

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned mismatches     = 0;
  int unsigned cycle_count    = 0;

  // split a number into decimal digits, leading zeros kept; too large is dropped
  function automatic void latch_number(input logic [VALUE_W-1:0] number);
    int unsigned rest;
    rest = number;
    if (rest >= VALUE_LIMIT) return;
    for (int i = 0; i < DIGIT_COUNT; i++) begin
      shown_digits[i] = DIGIT_W'(rest % 10);
      rest = rest / 10;
    end
  endfunction

  // the beat a refresh tick gives, most significant digit first
  function automatic display_beat_t next_display_beat();
    display_beat_t beat;
    logic [DIGIT_W-1:0] digit;
    digit = shown_digits[DIGIT_COUNT - 1 - scan_pos];
    beat.segments = (digit < 10) ? DIGIT_GLYPHS[digit] : '0;
    beat.enable   = (scan_pos < EN_W) ? EN_W'(1 << scan_pos) : '0;
    scan_pos = (scan_pos + 1 >= DIGIT_COUNT) ? 0 : scan_pos + 1;
    return beat;
  endfunction

  function automatic void note_mismatch(input string what, input display_beat_t want,
                                        input display_beat_t got);
    mismatches++;
    if (mismatches <= REPORT_MAX)
      $display("mismatch %0d: %s want seg=%h en=%b got seg=%h en=%b", mismatches, what,
               want.segments, want.enable, got.segments, got.enable);
  endfunction

  // offer one beat on the item channel, with random idle cycles ahead of it,
  // and return once it has been taken
  task automatic offer_item(input action_t act, input logic [VALUE_W-1:0] value);
    while ($urandom_range(99) < send_idle_pct) begin
      item_if.valid <= 1'b0;
      @(posedge clk);
    end
    item_if.valid  <= 1'b1;
    item_if.action <= act;
    item_if.value  <= value;
    do @(posedge clk); while (!item_if.ready);
  endtask

  // send one row and record what the display should answer with
  task automatic apply_item(input stim_row_t row);
    display_beat_t beat;
    offer_item(row.act, row.value);
    if (row.act == ACT_LOAD) begin
      latch_number(row.value);
    end else begin
      beat = next_display_beat();
      if (row.typed) begin
        beat.segments = row.segments;
        beat.enable   = row.enable;
      end
      pending_beats.push_back(beat);
    end
  endtask

  // random mix: mostly ticks, loads across the full range, a few too large
  task automatic random_items(input int count);
    stim_row_t row;
    int made;
    int pick;
    made = 0;
    while (made < count) begin
      pick = $urandom_range(99);
      row.typed    = 1'b0;
      row.segments = '0;
      row.enable   = '0;
      if (pick < 68) begin
        // tick value is don't-care to the block, so it rides along random
        row.act   = ACT_TICK;
        row.value = VALUE_W'($urandom_range(16383));
      end else if (pick < 90) begin
        row.act   = ACT_LOAD;
        row.value = VALUE_W'($urandom_range(9999));
      end else if (pick < 94) begin
        row.act   = ACT_LOAD;
        row.value = VALUE_W'($urandom_range(99));
      end else begin
        row.act   = ACT_LOAD;
        row.value = VALUE_W'($urandom_range(16383, 10000));
      end
      apply_item(row);
      // a dropped load changes nothing, so it does not count
      if (!(row.act == ACT_LOAD && row.value >= VALUE_LIMIT)) made++;
    end
  endtask

  // result side: check each accepted beat against the oldest expectation,
  // then pick the next ready at random
  always @(posedge clk) begin
    if (!rst && result_if.valid && result_if.ready) begin
      if (pending_beats.size() == 0) begin
        seen_want = '{segments: '0, enable: '0};
        note_mismatch("beat with nothing expected", seen_want,
                      '{segments: result_if.segments, enable: result_if.digit_enable});
      end else begin
        seen_want = pending_beats.pop_front();
        if (result_if.segments !== seen_want.segments ||
            result_if.digit_enable !== seen_want.enable)
          note_mismatch("wrong beat", seen_want,
                        '{segments: result_if.segments, enable: result_if.digit_enable});
      end
    end
    result_if.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    item_if.valid   <= 1'b0;
    item_if.action  <= ACT_LOAD;
    item_if.value   <= '0;
    for (int i = 0; i < DIGIT_COUNT; i++) shown_digits[i] = '0;
    scan_pos = 0;

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table, no idling on either side
    foreach (directed_rows[i]) apply_item(directed_rows[i]);
    random_items(ITEMS_PER_PHASE);

    // sender idles
    send_idle_pct  = 46;
    recv_stall_pct = 0;
    random_items(ITEMS_PER_PHASE);

    // receiver stalls
    send_idle_pct  = 0;
    recv_stall_pct = 46;
    random_items(ITEMS_PER_PHASE);

    // both sides idle
    send_idle_pct  = 34;
    recv_stall_pct = 34;
    random_items(ITEMS_PER_PHASE);

    item_if.valid <= 1'b0;
    while (pending_beats.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
